>>> hw/rtl/icr_pkg.sv
// Package for the interrupt controller register block.
// Holds shared constants, state, command and status types; no dependencies.
package icr_pkg;

    localparam int NUM_SOURCES   = 64;
    localparam int ENABLE_WORDS  = 64;
    localparam int PEND_WORDS    = NUM_SOURCES / 32;
    localparam int UART_SOURCE   = 10;
    localparam int VIRTIO_SOURCE = 1;
    localparam int CTX1_ENABLE   = 32;
    localparam int PRIO_AW       = $clog2(NUM_SOURCES);
    localparam int ENAB_AW       = $clog2(ENABLE_WORDS);
    localparam int PEND_AW       = (PEND_WORDS > 1) ? $clog2(PEND_WORDS) : 1;

    // Priority and enable words are kept in even and odd banks.
    localparam int PRIO_ROWS     = NUM_SOURCES / 2;
    localparam int ENAB_ROWS     = ENABLE_WORDS / 2;
    localparam int PRIO_RW       = PRIO_AW - 1;
    localparam int ENAB_RW       = ENAB_AW - 1;

    localparam logic [25:0] PEND_BASE = 26'h1000;
    localparam logic [25:0] ENAB_BASE = 26'h2000;
    localparam logic [25:0] THR0_ADDR = 26'h200000;
    localparam logic [25:0] CLM0_ADDR = 26'h200004;
    localparam logic [25:0] THR1_ADDR = 26'h201000;
    localparam logic [25:0] CLM1_ADDR = 26'h201004;

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRIO_READ,
        ST_RESP
    } state_t;

    // Controller commands to the datapath.
    typedef struct packed {
        logic exec;      // perform the captured item, priority array writes included
        logic prio_rd;   // result comes from the priority memory read
        logic respond;   // drive the result strobe
    } cmd_t;

    // Datapath status to the controller.
    typedef struct packed {
        logic prio_read; // captured item is a good priority read
        logic clearing;  // memories are still being cleared after reset
    } status_t;

endpackage

>>> hw/rtl/icr_ctrl.sv
// Controller state machine for the interrupt controller register block.
// Depends on icr_pkg.
module icr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  icr_pkg::status_t  status,
    output logic              busy,
    output icr_pkg::cmd_t     cmd
);

    icr_pkg::state_t state_reg;
    icr_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= icr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            icr_pkg::ST_IDLE:
            begin
                if (start && !status.clearing)
                begin
                    state_next = icr_pkg::ST_PRIO_READ;
                end
            end
            icr_pkg::ST_PRIO_READ: state_next = icr_pkg::ST_RESP;
            icr_pkg::ST_RESP:      state_next = icr_pkg::ST_IDLE;
            default:               state_next = icr_pkg::ST_IDLE;
        endcase
    end

    // The item is captured in IDLE; the memory read is issued in PRIO_READ and the
    // result leaves in RESP together with all state updates.
    always_comb
    begin
        busy = 1'b1;
        cmd  = '0;
        case (state_reg)
            icr_pkg::ST_IDLE: busy = status.clearing;
            icr_pkg::ST_PRIO_READ: ;
            icr_pkg::ST_RESP:
            begin
                cmd.exec    = 1'b1;
                cmd.prio_rd = status.prio_read;
                cmd.respond = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

>>> hw/rtl/icr_datapath.sv
// Register storage, address decode and tick logic of the interrupt controller.
// Depends on icr_pkg.
module icr_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              capture,
    input  logic [1:0]        mode,
    input  logic [25:0]       offset,
    input  logic [1:0]        access_size,
    input  logic [63:0]       write_data,
    input  logic              uart_request,
    input  logic              virtio_request,
    input  icr_pkg::cmd_t     cmd,
    output icr_pkg::status_t  status,
    output logic [31:0]       read_data,
    output logic              fault,
    output logic              raise_seip,
    output logic              done
);

    // Captured item.
    logic [1:0]  mode_reg;
    logic [25:0] off_reg;
    logic [1:0]  size_reg;
    logic [63:0] data_reg;
    logic        uart_reg;
    logic        virtio_reg;

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            mode_reg   <= mode;
            off_reg    <= offset;
            size_reg   <= access_size;
            data_reg   <= write_data;
            uart_reg   <= uart_request;
            virtio_reg <= virtio_request;
        end
    end

    // Memories: priority and enable words, each split into an even-row bank and
    // an odd-row bank so that a wide write touches each bank once. They are
    // cleared by a pass after reset.
    logic [31:0] prio_even [icr_pkg::PRIO_ROWS];
    logic [31:0] prio_odd  [icr_pkg::PRIO_ROWS];
    logic [31:0] enab_even [icr_pkg::ENAB_ROWS];
    logic [31:0] enab_odd  [icr_pkg::ENAB_ROWS];
    logic [31:0] pending_reg [icr_pkg::PEND_WORDS];
    logic [31:0] thr_reg [2];
    logic [5:0]  claim_reg [2];
    logic        update_reg;
    logic [31:0] ctx1_enable_reg;  // shadow copy of enable word 32
    logic [31:0] prio_even_rdata_reg;
    logic [31:0] prio_odd_rdata_reg;
    logic [31:0] prio_rdata;

    // Decode.
    logic aligned, in_prio, in_pend, in_enab, wide, rd_ok, wr_size_ok;
    logic [icr_pkg::PRIO_AW-1:0] prio_idx;
    logic [icr_pkg::ENAB_AW-1:0] enab_idx;
    logic [icr_pkg::PEND_AW-1:0] pend_idx;
    logic [icr_pkg::PRIO_RW-1:0] prio_row, prio_row_up;
    logic [icr_pkg::ENAB_RW-1:0] enab_row, enab_row_up;
    logic [25:0] pend_rel, enab_rel;
    logic last_prio, last_enab, last_pend;

    assign aligned    = off_reg[1:0] == 2'b00;
    assign pend_rel   = off_reg - icr_pkg::PEND_BASE;
    assign enab_rel   = off_reg - icr_pkg::ENAB_BASE;
    assign in_prio    = off_reg < 26'(icr_pkg::NUM_SOURCES * 4);
    assign in_pend    = off_reg >= icr_pkg::PEND_BASE
                        && pend_rel < 26'(icr_pkg::PEND_WORDS * 4);
    assign in_enab    = off_reg >= icr_pkg::ENAB_BASE
                        && enab_rel < 26'(icr_pkg::ENABLE_WORDS * 4);
    assign prio_idx   = off_reg[icr_pkg::PRIO_AW+1:2];
    assign enab_idx   = enab_rel[icr_pkg::ENAB_AW+1:2];
    assign pend_idx   = (icr_pkg::PEND_WORDS > 1) ? pend_rel[icr_pkg::PEND_AW+1:2] : '0;
    assign prio_row    = prio_idx[icr_pkg::PRIO_AW-1:1];
    assign prio_row_up = prio_row + 1'b1;
    assign enab_row    = enab_idx[icr_pkg::ENAB_AW-1:1];
    assign enab_row_up = enab_row + 1'b1;
    assign last_prio  = prio_idx == icr_pkg::PRIO_AW'(icr_pkg::NUM_SOURCES - 1);
    assign last_enab  = enab_idx == icr_pkg::ENAB_AW'(icr_pkg::ENABLE_WORDS - 1);
    assign last_pend  = pend_idx == icr_pkg::PEND_AW'(icr_pkg::PEND_WORDS - 1);
    assign wide       = size_reg == 2'd1;
    assign rd_ok      = size_reg == 2'd0 && aligned;
    assign wr_size_ok = (size_reg == 2'd0 || size_reg == 2'd1) && aligned;

    assign status.prio_read = mode_reg == icr_pkg::MODE_READ && rd_ok && in_prio;

    logic prio_we, prio_we2, enab_we, enab_we2, is_write;
    assign is_write = cmd.exec && mode_reg == icr_pkg::MODE_WRITE && wr_size_ok;
    assign prio_we  = is_write && in_prio;
    assign prio_we2 = prio_we && wide && !last_prio;
    assign enab_we  = is_write && !in_prio && !in_pend && in_enab;
    assign enab_we2 = enab_we && wide && !last_enab;

    // Clear sweep after reset: all banks, one row a cycle.
    localparam int CLR_DEPTH = (icr_pkg::PRIO_ROWS > icr_pkg::ENAB_ROWS)
                               ? icr_pkg::PRIO_ROWS : icr_pkg::ENAB_ROWS;
    localparam int CLR_W = $clog2(CLR_DEPTH + 1);
    logic [CLR_W-1:0] clr_reg;
    logic clearing;
    assign clearing = clr_reg != CLR_W'(CLR_DEPTH);
    assign status.clearing = clearing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (clearing)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    // A narrow write lands in the bank of its row. A wide write puts the low
    // half in the addressed row and the high half in the next row, which is
    // always in the other bank, so each bank sees at most one write a cycle.
    always_ff @(posedge clk)
    begin
        if (clearing)
        begin
            if (clr_reg < CLR_W'(icr_pkg::PRIO_ROWS))
            begin
                prio_even[clr_reg[icr_pkg::PRIO_RW-1:0]] <= '0;
                prio_odd[clr_reg[icr_pkg::PRIO_RW-1:0]]  <= '0;
            end
            if (clr_reg < CLR_W'(icr_pkg::ENAB_ROWS))
            begin
                enab_even[clr_reg[icr_pkg::ENAB_RW-1:0]] <= '0;
                enab_odd[clr_reg[icr_pkg::ENAB_RW-1:0]]  <= '0;
            end
        end
        else
        begin
            if (prio_we)
            begin
                if (prio_idx[0])
                begin
                    prio_odd[prio_row] <= data_reg[31:0];
                end
                else
                begin
                    prio_even[prio_row] <= data_reg[31:0];
                end
            end
            if (prio_we2)
            begin
                if (prio_idx[0])
                begin
                    prio_even[prio_row_up] <= data_reg[63:32];
                end
                else
                begin
                    prio_odd[prio_row] <= data_reg[63:32];
                end
            end
            if (enab_we)
            begin
                if (enab_idx[0])
                begin
                    enab_odd[enab_row] <= data_reg[31:0];
                end
                else
                begin
                    enab_even[enab_row] <= data_reg[31:0];
                end
            end
            if (enab_we2)
            begin
                if (enab_idx[0])
                begin
                    enab_even[enab_row_up] <= data_reg[63:32];
                end
                else
                begin
                    enab_odd[enab_row] <= data_reg[63:32];
                end
            end
        end
        prio_even_rdata_reg <= prio_even[prio_row];
        prio_odd_rdata_reg  <= prio_odd[prio_row];
    end

    assign prio_rdata = prio_idx[0] ? prio_odd_rdata_reg : prio_even_rdata_reg;

    // Enable words are read only through a registered port, one item at a time;
    // read enable data is registered while the controller is in PRIO_READ.
    logic [31:0] enab_even_rdata_reg;
    logic [31:0] enab_odd_rdata_reg;
    logic [31:0] enab_rdata;
    always_ff @(posedge clk)
    begin
        enab_even_rdata_reg <= enab_even[enab_row];
        enab_odd_rdata_reg  <= enab_odd[enab_row];
    end

    assign enab_rdata = enab_idx[0] ? enab_odd_rdata_reg : enab_even_rdata_reg;

    // Pending, threshold, claim and update state.
    logic [icr_pkg::PEND_WORDS-1:0][31:0] pend_next;
    logic [31:0] thr_next [2];
    logic [5:0]  claim_next [2];
    logic        update_next;
    logic [31:0] ctx1_next;
    logic [31:0] rd_val;
    logic        flt, seip;
    logic        claim_w;
    logic        claim_ctx;
    logic [58:0] claim_word;
    logic        p_uart, p_virt, e_uart, e_virt, upd;

    always_comb
    begin
        for (int i = 0; i < icr_pkg::PEND_WORDS; i++)
        begin
            pend_next[i] = pending_reg[i];
        end
        thr_next[0]   = thr_reg[0];
        thr_next[1]   = thr_reg[1];
        claim_next[0] = claim_reg[0];
        claim_next[1] = claim_reg[1];
        update_next   = update_reg;
        ctx1_next     = ctx1_enable_reg;
        rd_val        = '0;
        flt           = 1'b0;
        seip          = 1'b0;
        claim_w       = 1'b0;
        claim_ctx     = 1'b0;
        claim_word    = data_reg[63:5];
        p_uart        = 1'b0;
        p_virt        = 1'b0;
        e_uart        = 1'b0;
        e_virt        = 1'b0;
        upd           = 1'b0;

        if (enab_we && enab_idx == icr_pkg::ENAB_AW'(icr_pkg::CTX1_ENABLE))
        begin
            ctx1_next = data_reg[31:0];
        end
        if (enab_we2 && enab_idx + 1'b1 == icr_pkg::ENAB_AW'(icr_pkg::CTX1_ENABLE))
        begin
            ctx1_next = data_reg[63:32];
        end

        if (cmd.exec)
        begin
            case (mode_reg)
                icr_pkg::MODE_READ:
                begin
                    if (!rd_ok)
                    begin
                        flt = 1'b1;
                    end
                    else if (cmd.prio_rd)
                    begin
                        rd_val = prio_rdata;
                    end
                    else if (in_pend)
                    begin
                        rd_val = pending_reg[pend_idx];
                    end
                    else if (in_enab)
                    begin
                        rd_val = enab_rdata;
                    end
                    else if (off_reg == icr_pkg::THR0_ADDR)
                    begin
                        rd_val = thr_reg[0];
                    end
                    else if (off_reg == icr_pkg::CLM0_ADDR)
                    begin
                        rd_val = {26'd0, claim_reg[0]};
                    end
                    else if (off_reg == icr_pkg::THR1_ADDR)
                    begin
                        rd_val = thr_reg[1];
                    end
                    else if (off_reg == icr_pkg::CLM1_ADDR)
                    begin
                        rd_val = {26'd0, claim_reg[1]};
                    end
                    else
                    begin
                        flt = 1'b1;
                    end
                end
                icr_pkg::MODE_WRITE:
                begin
                    if (!wr_size_ok)
                    begin
                        flt = 1'b1;
                    end
                    else if (in_prio || in_enab && !in_pend)
                    begin
                        // handled by the memory write ports
                    end
                    else if (in_pend)
                    begin
                        pend_next[pend_idx] = data_reg[31:0];
                        if (wide && !last_pend)
                        begin
                            pend_next[pend_idx + 1'b1] = data_reg[63:32];
                        end
                    end
                    else if (wide)
                    begin
                        flt = 1'b1;
                    end
                    else if (off_reg == icr_pkg::THR0_ADDR)
                    begin
                        thr_next[0] = data_reg[31:0];
                    end
                    else if (off_reg == icr_pkg::CLM0_ADDR)
                    begin
                        claim_w = 1'b1;
                    end
                    else if (off_reg == icr_pkg::THR1_ADDR)
                    begin
                        thr_next[1] = data_reg[31:0];
                    end
                    else if (off_reg == icr_pkg::CLM1_ADDR)
                    begin
                        claim_w   = 1'b1;
                        claim_ctx = 1'b1;
                    end
                    else
                    begin
                        flt = 1'b1;
                    end
                    if (claim_w)
                    begin
                        if (claim_word < 59'(icr_pkg::PEND_WORDS))
                        begin
                            pend_next[claim_word[icr_pkg::PEND_AW-1:0]]
                                [data_reg[4:0]] = 1'b0;
                        end
                        claim_next[claim_ctx] = '0;
                        if (claim_ctx)
                        begin
                            update_next = 1'b1;
                        end
                    end
                end
                icr_pkg::MODE_TICK:
                begin
                    upd = update_reg | uart_reg | virtio_reg;
                    if (uart_reg)
                    begin
                        pend_next[icr_pkg::UART_SOURCE / 32][icr_pkg::UART_SOURCE % 32] = 1'b1;
                    end
                    if (virtio_reg)
                    begin
                        pend_next[icr_pkg::VIRTIO_SOURCE / 32]
                            [icr_pkg::VIRTIO_SOURCE % 32] = 1'b1;
                    end
                    p_uart = pend_next[icr_pkg::UART_SOURCE / 32][icr_pkg::UART_SOURCE % 32];
                    p_virt = pend_next[icr_pkg::VIRTIO_SOURCE / 32]
                        [icr_pkg::VIRTIO_SOURCE % 32];
                    e_uart = ctx1_enable_reg[icr_pkg::UART_SOURCE % 32];
                    e_virt = ctx1_enable_reg[icr_pkg::VIRTIO_SOURCE % 32];
                    if (upd)
                    begin
                        if (p_uart && e_uart)
                        begin
                            claim_next[1] = 6'(icr_pkg::UART_SOURCE);
                            seip = 1'b1;
                        end
                        else if (p_virt && e_virt)
                        begin
                            claim_next[1] = 6'(icr_pkg::VIRTIO_SOURCE);
                            seip = 1'b1;
                        end
                        else
                        begin
                            claim_next[1] = '0;
                        end
                        update_next = 1'b0;
                    end
                end
                default: ;
            endcase
        end
        if (flt)
        begin
            rd_val = '1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < icr_pkg::PEND_WORDS; i++)
            begin
                pending_reg[i] <= '0;
            end
            thr_reg[0]      <= '0;
            thr_reg[1]      <= '0;
            claim_reg[0]    <= '0;
            claim_reg[1]    <= '0;
            update_reg      <= 1'b0;
            ctx1_enable_reg <= '0;
            done            <= 1'b0;
            read_data       <= '0;
            fault           <= 1'b0;
            raise_seip      <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < icr_pkg::PEND_WORDS; i++)
            begin
                pending_reg[i] <= pend_next[i];
            end
            thr_reg[0]      <= thr_next[0];
            thr_reg[1]      <= thr_next[1];
            claim_reg[0]    <= claim_next[0];
            claim_reg[1]    <= claim_next[1];
            update_reg      <= update_next;
            ctx1_enable_reg <= ctx1_next;
            done            <= cmd.respond;
            read_data       <= rd_val;
            fault           <= flt;
            raise_seip      <= seip;
        end
    end

endmodule

>>> hw/rtl/interrupt_controller_registers.sv
// Top level of the platform interrupt controller register block.
// Depends on icr_pkg, icr_ctrl and icr_datapath.
//
// Usage: drive start with an item (bus read, bus write or tick) while busy is
// low. The item is captured at that edge and its single result appears on
// read_data, fault and raise_seip while done is high, for exactly one cycle
// that begins once PRIO_READ and RESP are passed and the result registered;
// the receiver cannot stall, so it must take the transfer in that cycle. One
// item is in flight at a time, so none is taken before the last is through:
// the registered read of the priority and enable memories, then execution
// with the result registered, then idle, at whose closing edge the next
// transfer can be accepted while the previous result is on the ports. After
// reset the block sweeps its memories clear, one row of each even and odd
// bank a cycle, over half the larger of the priority and enable depths; busy
// stays high during that sweep. A tick that finds an update marked or carries
// a request picks UART before VIRTIO among the sources pending and enabled in
// the context-1 enable word, loads claim 1 (zero if none) and raises raise_seip
// if one is picked. Priority and threshold are stored but do not affect the choice.
module interrupt_controller_registers (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [25:0] offset,
    input  logic [1:0]  access_size,
    input  logic [63:0] write_data,
    input  logic        uart_request,
    input  logic        virtio_request,
    output logic        done,
    output logic [31:0] read_data,
    output logic        fault,
    output logic        raise_seip
);

    icr_pkg::cmd_t    cmd;
    icr_pkg::status_t status;
    logic             capture;

    // An item is captured on the same edge that accepts it.
    assign capture = start && !busy;

    icr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    icr_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .capture        (capture),
        .mode           (mode),
        .offset         (offset),
        .access_size    (access_size),
        .write_data     (write_data),
        .uart_request   (uart_request),
        .virtio_request (virtio_request),
        .cmd            (cmd),
        .status         (status),
        .read_data      (read_data),
        .fault          (fault),
        .raise_seip     (raise_seip),
        .done           (done)
    );

endmodule

>>> sim/interrupt_controller_registers_test.sv
// Self-checking testbench for the interrupt controller register block.
// Depends on icr_pkg and interrupt_controller_registers; drives bus reads,
// bus writes and ticks and compares every result against its own model.
`timescale 1ns / 1ps

module interrupt_controller_registers_test;

    // One result of the block.
    typedef struct {
        logic [31:0] rdata;
        logic        flt;
        logic        seip;
    } plic_result_t;

    // Scoreboard: holds a private copy of the register state, computes the
    // expected result of each accepted transfer and checks what comes back.
    class plic_scoreboard;
        logic [31:0]  prio [icr_pkg::NUM_SOURCES];
        logic [31:0]  pend [icr_pkg::PEND_WORDS];
        logic [31:0]  enab [icr_pkg::ENABLE_WORDS];
        logic [31:0]  thr  [2];
        logic [5:0]   claim [2];
        bit           upd;
        plic_result_t pending_results[$];
        int           errors;
        int           checked;
        int           seip_seen;

        function new();
            foreach (prio[i]) prio[i] = '0;
            foreach (pend[i]) pend[i] = '0;
            foreach (enab[i]) enab[i] = '0;
            thr[0] = '0; thr[1] = '0;
            claim[0] = '0; claim[1] = '0;
            upd = 0;
            errors = 0; checked = 0; seip_seen = 0;
        endfunction

        // Claim completion: drop the pending bit of the named source if it
        // exists, zero the claim and, for context 1, mark an update.
        function void complete_claim(int ctx, logic [63:0] id);
            if ((id >> 5) < icr_pkg::PEND_WORDS)
                pend[id[5]] [id[4:0]] = 1'b0;
            if (ctx == 1)
                upd = 1;
            claim[ctx] = '0;
        endfunction

        function bit ready_ctx1(int src);
            return pend[src >> 5][src & 31] && enab[icr_pkg::CTX1_ENABLE][src & 31];
        endfunction

        // Note an accepted transfer and queue the result it should produce.
        function void note_transfer(logic [1:0] md, logic [25:0] off, logic [1:0] sz,
                                    logic [63:0] wd, logic ur, logic vr);
            plic_result_t r;
            bit wide;
            r.rdata = '0; r.flt = 0; r.seip = 0;
            wide = (sz == 2'd1);
            if (md == icr_pkg::MODE_READ) begin
                if (sz != 0 || off[1:0] != 0)
                    r.flt = 1;
                else if (off < icr_pkg::NUM_SOURCES * 4)
                    r.rdata = prio[off >> 2];
                else if (off >= icr_pkg::PEND_BASE
                         && off < icr_pkg::PEND_BASE + icr_pkg::PEND_WORDS * 4)
                    r.rdata = pend[(off - icr_pkg::PEND_BASE) >> 2];
                else if (off >= icr_pkg::ENAB_BASE
                         && off < icr_pkg::ENAB_BASE + icr_pkg::ENABLE_WORDS * 4)
                    r.rdata = enab[(off - icr_pkg::ENAB_BASE) >> 2];
                else if (off == icr_pkg::THR0_ADDR) r.rdata = thr[0];
                else if (off == icr_pkg::CLM0_ADDR) r.rdata = {26'd0, claim[0]};
                else if (off == icr_pkg::THR1_ADDR) r.rdata = thr[1];
                else if (off == icr_pkg::CLM1_ADDR) r.rdata = {26'd0, claim[1]};
                else r.flt = 1;
            end else if (md == icr_pkg::MODE_WRITE) begin
                int idx;
                if (sz > 1 || off[1:0] != 0)
                    r.flt = 1;
                else if (off < icr_pkg::NUM_SOURCES * 4) begin
                    idx = int'(off >> 2);
                    prio[idx] = wd[31:0];
                    if (wide && idx + 1 < icr_pkg::NUM_SOURCES) prio[idx + 1] = wd[63:32];
                end else if (off >= icr_pkg::PEND_BASE
                             && off < icr_pkg::PEND_BASE + icr_pkg::PEND_WORDS * 4) begin
                    idx = int'((off - icr_pkg::PEND_BASE) >> 2);
                    pend[idx] = wd[31:0];
                    if (wide && idx + 1 < icr_pkg::PEND_WORDS) pend[idx + 1] = wd[63:32];
                end else if (off >= icr_pkg::ENAB_BASE
                             && off < icr_pkg::ENAB_BASE + icr_pkg::ENABLE_WORDS * 4) begin
                    idx = int'((off - icr_pkg::ENAB_BASE) >> 2);
                    enab[idx] = wd[31:0];
                    if (wide && idx + 1 < icr_pkg::ENABLE_WORDS) enab[idx + 1] = wd[63:32];
                end else if (wide) r.flt = 1;
                else if (off == icr_pkg::THR0_ADDR) thr[0] = wd[31:0];
                else if (off == icr_pkg::CLM0_ADDR) complete_claim(0, wd);
                else if (off == icr_pkg::THR1_ADDR) thr[1] = wd[31:0];
                else if (off == icr_pkg::CLM1_ADDR) complete_claim(1, wd);
                else r.flt = 1;
            end else if (md == icr_pkg::MODE_TICK) begin
                if (ur) begin
                    pend[icr_pkg::UART_SOURCE >> 5][icr_pkg::UART_SOURCE & 31] = 1'b1;
                    upd = 1;
                end
                if (vr) begin
                    pend[icr_pkg::VIRTIO_SOURCE >> 5][icr_pkg::VIRTIO_SOURCE & 31] = 1'b1;
                    upd = 1;
                end
                if (upd) begin
                    if (ready_ctx1(icr_pkg::UART_SOURCE)) begin
                        claim[1] = 6'(icr_pkg::UART_SOURCE); r.seip = 1;
                    end else if (ready_ctx1(icr_pkg::VIRTIO_SOURCE)) begin
                        claim[1] = 6'(icr_pkg::VIRTIO_SOURCE); r.seip = 1;
                    end else
                        claim[1] = '0;
                    upd = 0;
                end
            end
            if (r.flt) r.rdata = '1;
            pending_results.push_back(r);
        endfunction

        // Compare one result from the block against the oldest expectation.
        function void check_result(logic [31:0] rd, logic f, logic s);
            plic_result_t e;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result read_data=%h fault=%b seip=%b",
                         $time, rd, f, s);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            checked++;
            if (s) seip_seen++;
            if (rd !== e.rdata) begin
                $display("%0t: read_data expected %h actual %h", $time, e.rdata, rd);
                errors++;
            end
            if (f !== e.flt) begin
                $display("%0t: fault expected %b actual %b", $time, e.flt, f);
                errors++;
            end
            if (s !== e.seip) begin
                $display("%0t: raise_seip expected %b actual %b", $time, e.seip, s);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        start = 0;
    logic [1:0]  mode = '0;
    logic [25:0] offset = '0;
    logic [1:0]  access_size = '0;
    logic [63:0] write_data = '0;
    logic        uart_request = 0;
    logic        virtio_request = 0;
    logic        busy, done, fault, raise_seip;
    logic [31:0] read_data;

    plic_scoreboard sb = new();
    int idle_pct;   // chance in percent that the sender leaves a cycle idle

    always #5 clk = ~clk;

    interrupt_controller_registers dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .mode(mode), .offset(offset), .access_size(access_size),
        .write_data(write_data), .uart_request(uart_request),
        .virtio_request(virtio_request), .done(done),
        .read_data(read_data), .fault(fault), .raise_seip(raise_seip)
    );

    // Results are sampled at the rising edge that ends their strobe cycle.
    always @(posedge clk)
        if (rst_n && done)
            sb.check_result(read_data, fault, raise_seip);

    // Drive one item: present it at a falling edge, keep start high until the
    // rising edge at which busy is low, then record the accepted transfer.
    // Random idle cycles are inserted beforehand according to idle_pct.
    task automatic send_item(logic [1:0] md, logic [25:0] off, logic [1:0] sz,
                             logic [63:0] wd, logic ur, logic vr);
        bit taken;
        while ($urandom_range(99) < idle_pct)
            @(negedge clk);
        mode = md; offset = off; access_size = sz;
        write_data = wd; uart_request = ur; virtio_request = vr;
        start = 1;
        taken = 0;
        while (!taken) begin
            @(posedge clk);
            if (!busy) begin
                taken = 1;
                sb.note_transfer(md, off, sz, wd, ur, vr);
            end
        end
        @(negedge clk);
        start = 0;
    endtask

    // Pick an offset: mostly mapped registers, sometimes misaligned or junk.
    function automatic logic [25:0] pick_offset();
        int sel;
        logic [25:0] o;
        sel = $urandom_range(99);
        if (sel < 15)      o = 26'($urandom_range(icr_pkg::NUM_SOURCES - 1) * 4);
        else if (sel < 35)
            o = 26'(icr_pkg::PEND_BASE + $urandom_range(icr_pkg::PEND_WORDS) * 4);
        else if (sel < 55) begin
            // Bias toward the context-1 enable word, which steers the choice.
            if ($urandom_range(1))
                o = 26'(icr_pkg::ENAB_BASE + icr_pkg::CTX1_ENABLE * 4);
            else
                o = 26'(icr_pkg::ENAB_BASE + $urandom_range(icr_pkg::ENABLE_WORDS) * 4);
        end
        else if (sel < 62) o = icr_pkg::THR0_ADDR;
        else if (sel < 70) o = icr_pkg::CLM0_ADDR;
        else if (sel < 77) o = icr_pkg::THR1_ADDR;
        else if (sel < 90) o = icr_pkg::CLM1_ADDR;
        else               o = 26'($urandom());
        if ($urandom_range(99) < 4) o[1:0] = 2'($urandom_range(1, 3));
        return o;
    endfunction

    // Random write data; claim-like writes mostly carry a small source id.
    function automatic logic [63:0] pick_data();
        case ($urandom_range(4))
            0: return {$urandom(), $urandom()};
            1: return 64'(icr_pkg::UART_SOURCE);
            2: return 64'(icr_pkg::VIRTIO_SOURCE);
            3: return 64'($urandom_range(127));
            default: return {32'(~$urandom() & 32'h0000_0403), 32'h0000_0402};
        endcase
    endfunction

    task automatic random_items(int count);
        int sel;
        logic [1:0] sz;
        repeat (count) begin
            sel = $urandom_range(99);
            sz = ($urandom_range(99) < 75) ? 2'd0 : 2'($urandom_range(3));
            if (sel < 35)
                send_item(icr_pkg::MODE_TICK, 26'($urandom()), 2'($urandom()),
                          {$urandom(), $urandom()}, 1'($urandom()), 1'($urandom()));
            else if (sel < 65)
                send_item(icr_pkg::MODE_WRITE, pick_offset(), sz, pick_data(),
                          1'($urandom()), 1'($urandom()));
            else if (sel < 97)
                send_item(icr_pkg::MODE_READ, pick_offset(), sz, {$urandom(), $urandom()},
                          1'($urandom()), 1'($urandom()));
            else
                send_item(2'd3, 26'($urandom()), 2'($urandom()), {$urandom(), $urandom()},
                          1'($urandom()), 1'($urandom()));
        end
    endtask

    // Safety net: the slowest run is about 1100 items.
    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int waited;
        idle_pct = 0;
        repeat (11) @(negedge clk);
        rst_n = 1;
        // Let the block finish clearing its memories after reset.
        repeat (80) @(negedge clk);

        // Directed part: array extremes, wide writes at array ends, claims,
        // bad sizes and alignment, unmapped offsets and the tick priority.
        send_item(icr_pkg::MODE_WRITE, 26'(icr_pkg::ENAB_BASE + icr_pkg::CTX1_ENABLE * 4),
                  2'd0, '1, 1'b0, 1'b0);
        send_item(icr_pkg::MODE_TICK, '0, 2'd0, '0, 1'b1, 1'b1);
        send_item(icr_pkg::MODE_READ, icr_pkg::CLM1_ADDR, 2'd0, '0, 1'b0, 1'b0);
        send_item(icr_pkg::MODE_WRITE, icr_pkg::CLM1_ADDR, 2'd0, 64'(icr_pkg::UART_SOURCE),
                  1'b0, 1'b0);
        send_item(icr_pkg::MODE_TICK, '0, 2'd0, '0, 1'b0, 1'b0);
        send_item(icr_pkg::MODE_READ, icr_pkg::PEND_BASE, 2'd0, '0, 1'b0, 1'b0);
        send_item(icr_pkg::MODE_WRITE, icr_pkg::CLM1_ADDR, 2'd0, 64'hFFFF_FFFF_FFFF_FFFF,
                  1'b0, 1'b0);
        send_item(icr_pkg::MODE_TICK, '1, 2'd3, '1, 1'b0, 1'b0);
        send_item(icr_pkg::MODE_WRITE, icr_pkg::CLM0_ADDR, 2'd0,
                  64'(icr_pkg::VIRTIO_SOURCE), 1'b0, 1'b0);
        send_item(icr_pkg::MODE_WRITE, 26'((icr_pkg::NUM_SOURCES - 1) * 4), 2'd1,
                  64'hDEAD_BEEF_0123_4567, 1'b0, 1'b0);
        send_item(icr_pkg::MODE_WRITE, 26'h0, 2'd1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
        send_item(icr_pkg::MODE_READ, 26'h4, 2'd0, '0, 1'b0, 1'b0);
        send_item(icr_pkg::MODE_WRITE, 26'(icr_pkg::PEND_BASE + 4), 2'd1,
                  64'h1234_5678_0000_0400, 1'b0, 1'b0);
        send_item(icr_pkg::MODE_WRITE,
                  26'(icr_pkg::ENAB_BASE + (icr_pkg::ENABLE_WORDS - 1) * 4), 2'd1, '1,
                  1'b0, 1'b0);
        send_item(icr_pkg::MODE_READ,
                  26'(icr_pkg::ENAB_BASE + (icr_pkg::ENABLE_WORDS - 1) * 4), 2'd0, '0,
                  1'b0, 1'b0);
        send_item(icr_pkg::MODE_WRITE, icr_pkg::THR1_ADDR, 2'd1, '1, 1'b0, 1'b0);
        send_item(icr_pkg::MODE_WRITE, icr_pkg::THR0_ADDR, 2'd0, '1, 1'b0, 1'b0);
        send_item(icr_pkg::MODE_READ, icr_pkg::THR0_ADDR, 2'd0, '0, 1'b0, 1'b0);
        send_item(icr_pkg::MODE_READ, icr_pkg::THR1_ADDR, 2'd1, '0, 1'b0, 1'b0);
        send_item(icr_pkg::MODE_READ, 26'h2, 2'd0, '0, 1'b0, 1'b0);
        send_item(icr_pkg::MODE_WRITE, 26'h1, 2'd2, '0, 1'b0, 1'b0);
        send_item(icr_pkg::MODE_READ, 26'h3FF_FFFC, 2'd0, '0, 1'b0, 1'b0);
        send_item(icr_pkg::MODE_READ, 26'(icr_pkg::PEND_BASE + icr_pkg::PEND_WORDS * 4),
                  2'd0, '0, 1'b0, 1'b0);
        send_item(2'd3, '1, 2'd3, '1, 1'b1, 1'b1);

        // Random part in phases of different sender idling.
        idle_pct = 0;  random_items(300);
        idle_pct = 60; random_items(250);
        idle_pct = 0;  random_items(250);
        idle_pct = 17; random_items(225);

        waited = 0;
        while (sb.pending_results.size() != 0 && waited < 1000) begin
            @(negedge clk);
            waited++;
        end
        repeat (10) @(negedge clk);
        if (sb.pending_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     sb.pending_results.size());
            sb.errors++;
        end

        $display("Checked %0d results from reads, writes and ticks, %0d raising SEIP,",
                 sb.checked, sb.seip_seen);
        $display("with sender idling phases of 0, 60 and 17 percent.");
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
